// ----- rtl/clcd_pkg.sv -----
// Shared types and constants for the 4-bit character LCD sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none
package clcd_pkg;

  localparam int E_PULSE_US    = 1;
  localparam int NIBBLE_GAP_US = 1;

  localparam int WAIT_W     = 20;
  localparam int HOLD_W     = 16;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);

  // request codes on the cmd field
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_INIT   = 2'd1;
  localparam logic [1:0] CMD_BYTE   = 2'd2;
  localparam logic [1:0] CMD_NIBBLE = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POWERUP_WAIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_HOLD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CMD_HOLD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_HOLD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FUNC_SET     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DISP_CTRL    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT        = 3'd6;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_INIT,
    KIND_BYTE,
    KIND_NIBBLE
  } clcd_kind_t;

  typedef struct packed {
    clcd_kind_t        kind;
    logic [7:0]        data_value;
    logic              reg_select;
    logic [HOLD_W-1:0] hold_us;
  } clcd_item_t;

  typedef struct packed {
    logic [QUEUE_LVL_W-1:0] level;
    logic                   full;
    logic                   empty;
  } clcd_queue_st_t;

  typedef struct packed {
    logic [WAIT_W-1:0] powerup_wait_us;
    logic [HOLD_W-1:0] init_nibble_hold_us;
    logic [HOLD_W-1:0] command_hold_us;
    logic [HOLD_W-1:0] clear_hold_us;
    logic [7:0]        function_set_code;
    logic [7:0]        display_control_code;
    logic [7:0]        shift_code;
  } clcd_cfg_t;

endpackage
`default_nettype wire

// ----- rtl/clcd_req_if.sv -----
// Request channel: valid/ready handshake carrying one input item.
// No dependencies.
`default_nettype none
interface clcd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  data_value;
  logic        reg_select;
  logic [15:0] hold_us;

  modport source (output valid, cmd, data_value, reg_select, hold_us, input ready);
  modport sink   (input valid, cmd, data_value, reg_select, hold_us, output ready);
endinterface
`default_nettype wire

// ----- rtl/clcd_res_if.sv -----
// Result channel: valid/ready handshake carrying pin levels and status.
// No dependencies.
`default_nettype none
interface clcd_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] lcd_nibble;
  logic       lcd_rs;
  logic       lcd_enable;
  logic       busy_res;
  logic       rejected;

  modport source (output valid, lcd_nibble, lcd_rs, lcd_enable, busy_res, rejected,
                  input ready);
  modport sink   (input valid, lcd_nibble, lcd_rs, lcd_enable, busy_res, rejected,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/clcd_front.sv -----
// Front end: accepts request items and classifies them for the queue.
// Depends on clcd_pkg and clcd_req_if.
`default_nettype none
module clcd_front
  import clcd_pkg::*;
(
  clcd_req_if.sink   req,
  input  wire logic  queue_full,
  output logic       push,
  output clcd_item_t push_item
);

  assign req.ready = !queue_full;
  assign push      = req.valid && !queue_full;

  always_comb begin
    push_item.data_value = req.data_value;
    push_item.reg_select = req.reg_select;
    push_item.hold_us    = req.hold_us;
    case (req.cmd)
      CMD_TICK:   push_item.kind = KIND_TICK;
      CMD_INIT:   push_item.kind = KIND_INIT;
      CMD_BYTE:   push_item.kind = KIND_BYTE;
      CMD_NIBBLE: begin
        push_item.kind       = KIND_NIBBLE;
        push_item.data_value = {4'h0, req.data_value[3:0]};
      end
      default:    push_item.kind = KIND_TICK;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/clcd_queue.sv -----
// Short item queue between the front end and the sequencer.
// Depends on clcd_pkg.
`default_nettype none
module clcd_queue
  import clcd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire clcd_item_t  push_item,
  input  wire logic        pop,
  output clcd_item_t       head_item,
  output clcd_queue_st_t   st
);

  clcd_item_t             mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_LVL_W-1:0] level;

  assign head_item = mem[rd_ptr];
  assign st.level  = level;
  assign st.full   = (level == QUEUE_LVL_W'(QUEUE_DEPTH));
  assign st.empty  = (level == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/clcd_back.sv -----
// Back end: nibble and init sequencer, timed by tick items, with result register.
// Depends on clcd_pkg and clcd_res_if.
`default_nettype none
module clcd_back
  import clcd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire clcd_cfg_t  cfg,
  input  wire clcd_item_t item,
  input  wire logic       item_avail,
  output logic            pop,
  clcd_res_if.source      res
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_POWERUP,
    PH_HIGH,
    PH_GAP,
    PH_LOW,
    PH_HOLD
  } phase_t;

  typedef struct packed {
    logic              whole;
    logic [7:0]        value;
    logic [HOLD_W-1:0] hold;
  } unit_t;

  localparam logic [3:0] STEP_IDLE    = 4'd0;
  localparam logic [3:0] STEP_POWERUP = 4'd1;
  localparam logic [3:0] STEP_NIB0    = 4'd2;
  localparam logic [3:0] STEP_NIB1    = 4'd3;
  localparam logic [3:0] STEP_NIB2    = 4'd4;
  localparam logic [3:0] STEP_NIB3    = 4'd5;
  localparam logic [3:0] STEP_FUNC    = 4'd6;
  localparam logic [3:0] STEP_DISP    = 4'd7;
  localparam logic [3:0] STEP_SHIFT   = 4'd8;

  localparam logic [7:0] LCD_WAKE_NIB  = 8'h03;
  localparam logic [7:0] LCD_4BIT_NIB  = 8'h02;
  localparam logic [7:0] LCD_CLEAR_CMD = 8'h01;

  function automatic unit_t init_unit(input logic [3:0] step, input clcd_cfg_t c);
    unit_t u;
    case (step)
      STEP_NIB0, STEP_NIB1, STEP_NIB2: u = '{1'b0, LCD_WAKE_NIB, c.init_nibble_hold_us};
      STEP_NIB3:  u = '{1'b0, LCD_4BIT_NIB, c.init_nibble_hold_us};
      STEP_FUNC:  u = '{1'b1, c.function_set_code, c.command_hold_us};
      STEP_DISP:  u = '{1'b1, c.display_control_code, c.command_hold_us};
      STEP_SHIFT: u = '{1'b1, c.shift_code, c.command_hold_us};
      default:    u = '{1'b1, LCD_CLEAR_CMD, c.clear_hold_us};
    endcase
    return u;
  endfunction

  phase_t            phase, phase_next;
  logic [3:0]        init_step, init_step_next;
  logic [WAIT_W-1:0] wait_count, wait_count_next;
  logic [7:0]        held_byte, held_byte_next;
  logic              held_rs, held_rs_next;
  logic [HOLD_W-1:0] held_hold, held_hold_next;
  logic [3:0]        pin_nib, pin_nib_next;
  logic              pin_e, pin_e_next;
  logic              pin_rs, pin_rs_next;
  logic              rej;

  logic              go;
  unit_t             go_unit;
  logic              go_rs;
  logic              out_valid;
  logic [3:0]        out_nib;
  logic              out_rs, out_e, out_busy, out_rej;

  assign pop = item_avail && (!out_valid || res.ready);

  always_comb begin
    phase_next      = phase;
    init_step_next  = init_step;
    wait_count_next = wait_count;
    held_byte_next  = held_byte;
    held_rs_next    = held_rs;
    held_hold_next  = held_hold;
    pin_nib_next    = pin_nib;
    pin_e_next      = pin_e;
    pin_rs_next     = pin_rs;
    rej             = 1'b0;
    go              = 1'b0;
    go_unit         = '{item.kind == KIND_BYTE, item.data_value, item.hold_us};
    go_rs           = item.reg_select;

    if (item.kind == KIND_TICK) begin
      if (phase != PH_IDLE) begin
        if (wait_count > WAIT_W'(1)) begin
          wait_count_next = wait_count - 1'b1;
        end else begin
          case (phase)
            PH_POWERUP: begin
              init_step_next = STEP_NIB0;
              go             = 1'b1;
              go_unit        = init_unit(STEP_NIB0, cfg);
              go_rs          = 1'b0;
            end
            PH_HIGH: begin
              pin_e_next      = 1'b0;
              phase_next      = PH_GAP;
              wait_count_next = WAIT_W'(NIBBLE_GAP_US);
            end
            PH_GAP: begin
              pin_nib_next    = held_byte[3:0];
              pin_rs_next     = held_rs;
              pin_e_next      = 1'b1;
              phase_next      = PH_LOW;
              wait_count_next = WAIT_W'(E_PULSE_US);
            end
            PH_LOW: begin
              pin_e_next      = 1'b0;
              phase_next      = PH_HOLD;
              wait_count_next = (held_hold == '0) ? WAIT_W'(1) : WAIT_W'(held_hold);
            end
            default: begin
              if (init_step >= STEP_NIB0 && init_step <= STEP_SHIFT) begin
                init_step_next = init_step + 1'b1;
                go             = 1'b1;
                go_unit        = init_unit(init_step + 1'b1, cfg);
                go_rs          = 1'b0;
              end else begin
                init_step_next  = STEP_IDLE;
                phase_next      = PH_IDLE;
                wait_count_next = '0;
              end
            end
          endcase
        end
      end
    end else if (phase != PH_IDLE) begin
      rej = 1'b1;
    end else if (item.kind == KIND_INIT) begin
      init_step_next  = STEP_POWERUP;
      phase_next      = PH_POWERUP;
      wait_count_next = (cfg.powerup_wait_us == '0) ? WAIT_W'(1) : cfg.powerup_wait_us;
    end else begin
      go = 1'b1;
    end

    if (go) begin
      held_byte_next  = go_unit.value;
      held_rs_next    = go_rs;
      held_hold_next  = go_unit.hold;
      pin_nib_next    = go_unit.whole ? go_unit.value[7:4] : go_unit.value[3:0];
      pin_rs_next     = go_rs;
      pin_e_next      = 1'b1;
      phase_next      = go_unit.whole ? PH_HIGH : PH_LOW;
      wait_count_next = WAIT_W'(E_PULSE_US);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      init_step  <= STEP_IDLE;
      wait_count <= '0;
      held_byte  <= '0;
      held_rs    <= 1'b0;
      held_hold  <= '0;
      pin_nib    <= '0;
      pin_e      <= 1'b0;
      pin_rs     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        phase      <= phase_next;
        init_step  <= init_step_next;
        wait_count <= wait_count_next;
        held_byte  <= held_byte_next;
        held_rs    <= held_rs_next;
        held_hold  <= held_hold_next;
        pin_nib    <= pin_nib_next;
        pin_e      <= pin_e_next;
        pin_rs     <= pin_rs_next;
        out_valid  <= 1'b1;
        out_nib    <= pin_nib_next;
        out_rs     <= pin_rs_next;
        out_e      <= pin_e_next;
        out_busy   <= (phase_next != PH_IDLE);
        out_rej    <= rej;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign res.valid      = out_valid;
  assign res.lcd_nibble = out_nib;
  assign res.lcd_rs     = out_rs;
  assign res.lcd_enable = out_e;
  assign res.busy_res   = out_busy;
  assign res.rejected   = out_rej;

endmodule
`default_nettype wire

// ----- rtl/char_lcd_4bit_sequencer.sv -----
// Top level of the 4-bit character LCD sequencer: config registers, front end,
// item queue and sequencer. Depends on clcd_pkg, clcd_req_if, clcd_res_if,
// clcd_front, clcd_queue and clcd_back.
//
// Usage: every request item is a one-microsecond tick or a request (start init,
// write byte, write nibble). Each item yields exactly one result item with the
// LCD pin levels after it, a busy flag and a rejected flag. Requests that
// arrive while a sequence or hold runs are dropped and flagged as rejected.
// Only tick items advance time; feed one per microsecond.
// A result is offered from the result register after its item has passed
// through the queue. Throughput: one item per cycle while the result receiver
// keeps up; each sequencer update consumes one queued item when it pops.
// A four-entry queue separates the request side from the sequencer, and the
// next item is popped in the same cycle the waiting result is taken.
// When the result receiver stalls, the sequencer holds and the queue fills;
// req.ready drops once four items wait.
// Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect next cycle;
// write only while idle. Indexes beyond the list are ignored.
// Reset (rst, synchronous) restores default timings and codes, idles the
// sequencer, clears its LCD pin registers and the result valid flag, and empties the queue.
`default_nettype none
module char_lcd_4bit_sequencer
  import clcd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  clcd_req_if.sink                   req,
  clcd_res_if.source                 res,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  clcd_cfg_t      cfg;
  logic           push;
  logic           pop;
  clcd_item_t     push_item;
  clcd_item_t     head_item;
  clcd_queue_st_t q_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.powerup_wait_us      <= WAIT_W'(100000);
      cfg.init_nibble_hold_us  <= HOLD_W'(5000);
      cfg.command_hold_us      <= HOLD_W'(50);
      cfg.clear_hold_us        <= HOLD_W'(2000);
      cfg.function_set_code    <= 8'h28;
      cfg.display_control_code <= 8'h0c;
      cfg.shift_code           <= 8'h14;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_POWERUP_WAIT: cfg.powerup_wait_us      <= cfg_data[WAIT_W-1:0];
        CFG_INIT_HOLD:    cfg.init_nibble_hold_us  <= cfg_data[HOLD_W-1:0];
        CFG_CMD_HOLD:     cfg.command_hold_us      <= cfg_data[HOLD_W-1:0];
        CFG_CLEAR_HOLD:   cfg.clear_hold_us        <= cfg_data[HOLD_W-1:0];
        CFG_FUNC_SET:     cfg.function_set_code    <= cfg_data[7:0];
        CFG_DISP_CTRL:    cfg.display_control_code <= cfg_data[7:0];
        CFG_SHIFT:        cfg.shift_code           <= cfg_data[7:0];
        default:          cfg <= cfg;
      endcase
    end
  end

  clcd_front u_front (
    .req        (req),
    .queue_full (q_st.full),
    .push       (push),
    .push_item  (push_item)
  );

  clcd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .st        (q_st)
  );

  clcd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item       (head_item),
    .item_avail (!q_st.empty),
    .pop        (pop),
    .res        (res)
  );

  a_rej_busy: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.rejected |-> res.busy_res)
    else $error("rejected result while sequencer idle");

  a_enable_busy: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.lcd_enable |-> res.busy_res)
    else $error("E strobe high while sequencer idle");

  a_queue_level: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (int'(q_st.level) ==
      int'($past(q_st.level)) + int'($past(push)) - int'($past(pop))))
    else $error("queue level does not track push and pop");

endmodule
`default_nettype wire

// ----- tb/char_lcd_4bit_sequencer_test.sv -----
// Self-checking testbench for char_lcd_4bit_sequencer: directed table, then random phases
// under random sender bursts and receiver stalls, checked against a cycle-free LCD predictor.
// Depends on clcd_pkg, clcd_req_if, clcd_res_if and the RTL of the block.
module char_lcd_4bit_sequencer_test;
  import clcd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 3_000_000;
  localparam int     N_PHASES    = 9;
  localparam int     PHASE_ITEMS = 45;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  localparam logic [3:0] STEP_NONE    = 4'd0;
  localparam logic [3:0] STEP_POWERUP = 4'd1;
  localparam logic [3:0] STEP_WAKE_1  = 4'd2;
  localparam logic [3:0] STEP_WAKE_2  = 4'd3;
  localparam logic [3:0] STEP_WAKE_3  = 4'd4;
  localparam logic [3:0] STEP_4BIT    = 4'd5;
  localparam logic [3:0] STEP_FUNC    = 4'd6;
  localparam logic [3:0] STEP_DISP    = 4'd7;
  localparam logic [3:0] STEP_SHIFT   = 4'd8;

  localparam logic [7:0] WAKE_NIBBLE  = 8'h03;
  localparam logic [7:0] MODE_NIBBLE  = 8'h02;
  localparam logic [7:0] CLEAR_CMD    = 8'h01;

  typedef enum logic [2:0] {
    PH_IDLE, PH_POWERUP, PH_HIGH_E, PH_GAP, PH_LAST_E, PH_HOLD
  } seq_phase_t;

  typedef struct packed {
    logic [3:0] nib;
    logic       rs;
    logic       en;
    logic       busy;
    logic       rej;
  } lcd_pins_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  data;
    logic        rs;
    logic [15:0] hold;
    logic        typed;
    lcd_pins_t   want;
  } dir_row_t;

  // typed rows: reset state, busy refusals, high bits of a nibble write ignored
  localparam dir_row_t DIR_ROWS [25] = '{
    '{CMD_TICK,   8'h00, 1'b0, 16'h0000, 1'b1, '{4'h0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{CMD_BYTE,   8'hff, 1'b1, 16'h0000, 1'b1, '{4'hf, 1'b1, 1'b1, 1'b1, 1'b0}},
    '{CMD_NIBBLE, 8'h00, 1'b0, 16'h0000, 1'b1, '{4'hf, 1'b1, 1'b1, 1'b1, 1'b1}},
    '{CMD_INIT,   8'h00, 1'b0, 16'h0000, 1'b1, '{4'hf, 1'b1, 1'b1, 1'b1, 1'b1}},
    '{CMD_TICK,   8'hff, 1'b1, 16'hffff, 1'b0, '0},
    '{CMD_BYTE,   8'h12, 1'b0, 16'h0005, 1'b1, '{4'hf, 1'b1, 1'b0, 1'b1, 1'b1}},
    '{CMD_TICK,   8'h00, 1'b0, 16'h0000, 1'b0, '0},
    '{CMD_TICK,   8'h00, 1'b0, 16'h0000, 1'b0, '0},
    '{CMD_TICK,   8'h00, 1'b0, 16'h0000, 1'b0, '0},
    '{CMD_TICK,   8'h00, 1'b0, 16'h0000, 1'b1, '{4'hf, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{CMD_NIBBLE, 8'hf0, 1'b0, 16'h0000, 1'b1, '{4'h0, 1'b0, 1'b1, 1'b1, 1'b0}},
    '{CMD_TICK,   8'h00, 1'b0, 16'h0000, 1'b0, '0},
    '{CMD_TICK,   8'h00, 1'b0, 16'h0000, 1'b0, '0},
    '{CMD_NIBBLE, 8'haf, 1'b1, 16'h0003, 1'b1, '{4'hf, 1'b1, 1'b1, 1'b1, 1'b0}},
    '{CMD_TICK,   8'h00, 1'b0, 16'h0000, 1'b0, '0},
    '{CMD_TICK,   8'h00, 1'b0, 16'h0000, 1'b0, '0},
    '{CMD_TICK,   8'h00, 1'b0, 16'h0000, 1'b0, '0},
    '{CMD_TICK,   8'h00, 1'b0, 16'h0000, 1'b0, '0},
    '{CMD_BYTE,   8'h5a, 1'b1, 16'h0001, 1'b1, '{4'h5, 1'b1, 1'b1, 1'b1, 1'b0}},
    '{CMD_TICK,   8'h00, 1'b0, 16'h0000, 1'b0, '0},
    '{CMD_TICK,   8'h00, 1'b0, 16'h0000, 1'b0, '0},
    '{CMD_TICK,   8'h00, 1'b0, 16'h0000, 1'b0, '0},
    '{CMD_TICK,   8'h00, 1'b0, 16'h0000, 1'b0, '0},
    '{CMD_TICK,   8'h00, 1'b0, 16'h0000, 1'b0, '0},
    '{CMD_BYTE,   8'h00, 1'b0, 16'h0020, 1'b1, '{4'h0, 1'b0, 1'b1, 1'b1, 1'b0}}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  clcd_req_if req_ch();
  clcd_res_if res_ch();

  char_lcd_4bit_sequencer u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .res       (res_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  clcd_cfg_t   cfg_now;
  logic [3:0]  seq_step;
  seq_phase_t  seq_phase;
  logic [19:0] seq_wait;
  logic [7:0]  seq_byte;
  logic        seq_rs;
  logic [15:0] seq_hold;
  logic [3:0]  pin_nib;
  logic        pin_rs;
  logic        pin_en;

  lcd_pins_t pins_due[$];

  int     burst_left = 0;
  int     gap_left   = 0;
  int     n_items    = 0;
  int     n_active   = 0;
  int     n_refused  = 0;
  int     n_inits    = 0;
  int     n_checked  = 0;
  int     n_bad      = 0;
  int     n_settings = 0;
  longint cycle_count = 0;

  function automatic void load_unit(input bit whole, input logic [7:0] v, input logic rs,
                                    input logic [15:0] h);
    seq_byte = v;
    seq_rs   = rs;
    seq_hold = h;
    pin_rs   = rs;
    pin_en   = 1'b1;
    if (whole) begin
      pin_nib   = v[7:4];
      seq_phase = PH_HIGH_E;
    end else begin
      pin_nib   = v[3:0];
      seq_phase = PH_LAST_E;
    end
    seq_wait = 20'(E_PULSE_US);
  endfunction

  function automatic void load_init_unit();
    case (seq_step)
      STEP_WAKE_1, STEP_WAKE_2, STEP_WAKE_3:
        load_unit(1'b0, WAKE_NIBBLE, 1'b0, cfg_now.init_nibble_hold_us);
      STEP_4BIT:  load_unit(1'b0, MODE_NIBBLE, 1'b0, cfg_now.init_nibble_hold_us);
      STEP_FUNC:  load_unit(1'b1, cfg_now.function_set_code, 1'b0, cfg_now.command_hold_us);
      STEP_DISP:  load_unit(1'b1, cfg_now.display_control_code, 1'b0, cfg_now.command_hold_us);
      STEP_SHIFT: load_unit(1'b1, cfg_now.shift_code, 1'b0, cfg_now.command_hold_us);
      default:    load_unit(1'b1, CLEAR_CMD, 1'b0, cfg_now.clear_hold_us);
    endcase
  endfunction

  // advances the LCD state by one item and returns the pin levels and flags after it
  function automatic lcd_pins_t lcd_apply_item(input logic [1:0] c, input logic [7:0] d,
                                               input logic rs, input logic [15:0] h);
    lcd_pins_t r;
    logic      rej;
    rej = 1'b0;
    if (c == CMD_TICK) begin
      if (seq_phase != PH_IDLE) begin
        n_active++;
        if (seq_wait > 20'd1) begin
          seq_wait = seq_wait - 1'b1;
        end else begin
          case (seq_phase)
            PH_POWERUP: begin
              seq_step = STEP_WAKE_1;
              load_init_unit();
            end
            PH_HIGH_E: begin
              pin_en    = 1'b0;
              seq_phase = PH_GAP;
              seq_wait  = 20'(NIBBLE_GAP_US);
            end
            PH_GAP: begin
              pin_nib   = seq_byte[3:0];
              pin_rs    = seq_rs;
              pin_en    = 1'b1;
              seq_phase = PH_LAST_E;
              seq_wait  = 20'(E_PULSE_US);
            end
            PH_LAST_E: begin
              pin_en    = 1'b0;
              seq_phase = PH_HOLD;
              seq_wait  = (seq_hold == 16'd0) ? 20'd1 : 20'(seq_hold);
            end
            default: begin
              if (seq_step >= STEP_WAKE_1 && seq_step <= STEP_SHIFT) begin
                seq_step = seq_step + 1'b1;
                load_init_unit();
              end else begin
                seq_step  = STEP_NONE;
                seq_phase = PH_IDLE;
                seq_wait  = '0;
              end
            end
          endcase
        end
      end
    end else if (seq_phase != PH_IDLE) begin
      rej = 1'b1;
      n_refused++;
    end else begin
      n_active++;
      if (c == CMD_INIT) begin
        n_inits++;
        seq_step  = STEP_POWERUP;
        seq_phase = PH_POWERUP;
        seq_wait  = (cfg_now.powerup_wait_us == '0) ? 20'd1 : cfg_now.powerup_wait_us;
      end else if (c == CMD_BYTE) begin
        load_unit(1'b1, d, rs, h);
      end else begin
        load_unit(1'b0, {4'h0, d[3:0]}, rs, h);
      end
    end
    r.nib  = pin_nib;
    r.rs   = pin_rs;
    r.en   = pin_en;
    r.busy = (seq_phase != PH_IDLE);
    r.rej  = rej;
    return r;
  endfunction

  task automatic send_item(input logic [1:0] c, input logic [7:0] d, input logic rs,
                           input logic [15:0] h, input logic typed, input lcd_pins_t want);
    lcd_pins_t pred;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    @(negedge clk);
    if (gap_left != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap_left) @(negedge clk);
      gap_left = 0;
    end
    req_ch.valid      <= 1'b1;
    req_ch.cmd        <= c;
    req_ch.data_value <= d;
    req_ch.reg_select <= rs;
    req_ch.hold_us    <= h;
    do @(posedge clk); while (!req_ch.ready);
    pred = lcd_apply_item(c, d, rs, h);
    pins_due.push_back(typed ? want : pred);
    n_items++;
  endtask

  task automatic hold_off();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pins_due.size() != 0) @(posedge clk);
  endtask

  // tick until the sequencer is idle, then wait for every result
  task automatic settle();
    while (seq_phase != PH_IDLE)
      send_item(CMD_TICK, 8'($urandom), 1'($urandom), 16'($urandom), 1'b0, '0);
    hold_off();
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_POWERUP_WAIT: cfg_now.powerup_wait_us      = v;
      CFG_INIT_HOLD:    cfg_now.init_nibble_hold_us  = v[15:0];
      CFG_CMD_HOLD:     cfg_now.command_hold_us      = v[15:0];
      CFG_CLEAR_HOLD:   cfg_now.clear_hold_us        = v[15:0];
      CFG_FUNC_SET:     cfg_now.function_set_code    = v[7:0];
      CFG_DISP_CTRL:    cfg_now.display_control_code = v[7:0];
      CFG_SHIFT:        cfg_now.shift_code           = v[7:0];
      default: ;
    endcase
  endtask

  task automatic configure(input clcd_cfg_t c);
    write_reg(CFG_POWERUP_WAIT, c.powerup_wait_us);
    write_reg(CFG_INIT_HOLD, 20'(c.init_nibble_hold_us));
    write_reg(CFG_CMD_HOLD, 20'(c.command_hold_us));
    write_reg(CFG_CLEAR_HOLD, 20'(c.clear_hold_us));
    write_reg(CFG_FUNC_SET, 20'(c.function_set_code));
    write_reg(CFG_DISP_CTRL, 20'(c.display_control_code));
    write_reg(CFG_SHIFT, 20'(c.shift_code));
    // unmapped index must leave every register alone
    write_reg(CFG_UNUSED_IDX, 20'($urandom));
    n_settings++;
  endtask

  // mostly well-formed: requests while idle, ticks while busy, some refused requests
  task automatic random_item(input bit allow_init);
    int          r;
    logic [1:0]  c;
    logic [15:0] h;
    r = $urandom_range(0, 99);
    if (seq_phase == PH_IDLE) begin
      if (r < 6)
        c = CMD_TICK;
      else if (allow_init && r < 22)
        c = CMD_INIT;
      else if (r < 62)
        c = CMD_BYTE;
      else
        c = CMD_NIBBLE;
      h = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
    end else begin
      c = (r < 10) ? 2'($urandom_range(1, 3)) : CMD_TICK;
      h = 16'($urandom);
    end
    send_item(c, 8'($urandom), 1'($urandom), h, 1'b0, '0);
  endtask

  always @(posedge clk) begin : result_check
    lcd_pins_t seen;
    lcd_pins_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      seen = {res_ch.lcd_nibble, res_ch.lcd_rs, res_ch.lcd_enable,
              res_ch.busy_res, res_ch.rejected};
      n_checked++;
      if (pins_due.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("result %0d arrived with nothing expected: nib=%h rs=%b e=%b busy=%b rej=%b",
                   n_checked, seen.nib, seen.rs, seen.en, seen.busy, seen.rej);
      end else begin
        want = pins_due.pop_front();
        if (seen !== want) begin
          n_bad++;
          if (n_bad <= 10)
            $display({"result %0d mismatch: expected nib=%h rs=%b e=%b busy=%b rej=%b,",
                      " got nib=%h rs=%b e=%b busy=%b rej=%b"}, n_checked,
                     want.nib, want.rs, want.en, want.busy, want.rej,
                     seen.nib, seen.rs, seen.en, seen.busy, seen.rej);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("no completion after %0d cycles, %0d results outstanding",
               cycle_count, pins_due.size());
      $display("char_lcd_4bit_sequencer_test: errors");
      $finish;
    end
  end

  // receiver: ready runs broken by short stalls, now and then a long stall-free stretch
  initial begin : result_pacing
    int run;
    int stall;
    res_ch.ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 9) == 0) begin
        run   = $urandom_range(100, 300);
        stall = 0;
      end else begin
        run   = $urandom_range(1, 24);
        stall = $urandom_range(1, 8);
      end
      @(negedge clk);
      res_ch.ready <= 1'b1;
      repeat (run - 1) @(negedge clk);
      if (stall != 0) begin
        @(negedge clk);
        res_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    clcd_cfg_t c;
    int        goal;
    req_ch.valid      = 1'b0;
    req_ch.cmd        = CMD_TICK;
    req_ch.data_value = '0;
    req_ch.reg_select = 1'b0;
    req_ch.hold_us    = '0;

    cfg_now.powerup_wait_us      = 20'd100000;
    cfg_now.init_nibble_hold_us  = 16'd5000;
    cfg_now.command_hold_us      = 16'd50;
    cfg_now.clear_hold_us        = 16'd2000;
    cfg_now.function_set_code    = 8'h28;
    cfg_now.display_control_code = 8'h0c;
    cfg_now.shift_code           = 8'h14;
    seq_step  = STEP_NONE;
    seq_phase = PH_IDLE;
    seq_wait  = '0;
    seq_byte  = '0;
    seq_rs    = 1'b0;
    seq_hold  = '0;
    pin_nib   = '0;
    pin_rs    = 1'b0;
    pin_en    = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < $size(DIR_ROWS); i++)
      send_item(DIR_ROWS[i].cmd, DIR_ROWS[i].data, DIR_ROWS[i].rs, DIR_ROWS[i].hold,
                DIR_ROWS[i].typed, DIR_ROWS[i].want);
    settle();

    // init with every wait at zero
    c.powerup_wait_us      = '0;
    c.init_nibble_hold_us  = '0;
    c.command_hold_us      = '0;
    c.clear_hold_us        = '0;
    c.function_set_code    = 8'hff;
    c.display_control_code = 8'h00;
    c.shift_code           = 8'($urandom);
    configure(c);
    send_item(CMD_INIT, 8'($urandom), 1'b1, 16'($urandom), 1'b0, '0);
    settle();

    // init with a long clear hold
    c.powerup_wait_us      = 20'd3;
    c.init_nibble_hold_us  = 16'd1;
    c.command_hold_us      = 16'd2;
    c.clear_hold_us        = 16'd40;
    c.function_set_code    = 8'h00;
    c.display_control_code = 8'hff;
    c.shift_code           = 8'($urandom);
    configure(c);
    send_item(CMD_INIT, 8'($urandom), 1'b0, 16'($urandom), 1'b0, '0);
    settle();

    for (int p = 0; p < N_PHASES; p++) begin
      if (p == 0) begin
        // register maxima; init stays off so the run length stays bounded
        c.powerup_wait_us      = 20'hfffff;
        c.init_nibble_hold_us  = 16'hffff;
        c.command_hold_us      = 16'hffff;
        c.clear_hold_us        = 16'hffff;
        c.function_set_code    = 8'hff;
        c.display_control_code = 8'hff;
        c.shift_code           = 8'hff;
      end else begin
        c.powerup_wait_us      = 20'($urandom_range(0, 24));
        c.init_nibble_hold_us  = 16'($urandom_range(0, 5));
        c.command_hold_us      = 16'($urandom_range(0, 5));
        c.clear_hold_us        = 16'($urandom_range(0, 5));
        c.function_set_code    = 8'($urandom);
        c.display_control_code = 8'($urandom);
        c.shift_code           = 8'($urandom);
      end
      configure(c);
      goal = n_active + PHASE_ITEMS;
      while (n_active < goal) begin
        random_item(p != 0);
        if ($urandom_range(0, 49) == 0)
          hold_off();
      end
      settle();
    end

    repeat (20) @(posedge clk);
    $display("%0d items sent, %0d advanced the sequencer, %0d results checked",
             n_items, n_active, n_checked);
    $display("%0d init sequences, %0d requests refused while busy, %0d register settings",
             n_inits, n_refused, n_settings);
    if (n_bad == 0)
      $display("char_lcd_4bit_sequencer_test: clean");
    else
      $display("char_lcd_4bit_sequencer_test: errors");
    $finish;
  end

endmodule
